@@ src/swept_aabb_collision_unit_defines.svh @@
// assertion macros for the swept box collision unit checker
// used by sac_checker; relies on clk and rst in the including scope
`ifndef SWEPT_AABB_COLLISION_UNIT_DEFINES_SVH
`define SWEPT_AABB_COLLISION_UNIT_DEFINES_SVH

// same-cycle implication
`define SAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sac_pkg.sv @@
// types, constants and helpers for the swept box collision unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  localparam int COORD_BITS     = 24;
  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int COORD_FRAC     = 8;
  localparam int VEL_BITS       = 17;
  localparam int RV_BITS        = VEL_BITS + 1;
  localparam int D_BITS         = COORD_BITS + 3;
  localparam int TIME_FRAC_BITS = 16;
  localparam int Q_BITS         = TIME_FRAC_BITS + 1;
  localparam int DV_BITS        = VEL_BITS;
  localparam int R_BITS         = DV_BITS + 1;
  localparam int T_BITS         = Q_BITS + 2;
  localparam int N_CELLS        = Q_BITS;
  localparam int N_LANES        = 4;

  localparam logic [Q_BITS-1:0] TIME_ONE = Q_BITS'(1) << TIME_FRAC_BITS;
  localparam logic signed [D_BITS-1:0] SLACK = D_BITS'(1) << COORD_FRAC;

  typedef enum logic [2:0] {
    SIDE_ABOVE,
    SIDE_BELOW,
    SIDE_RIGHT,
    SIDE_LEFT,
    SIDE_NONE
  } side_t;

  typedef enum logic [1:0] {
    LK_DIV,
    LK_NEG,
    LK_BIG
  } lane_kind_t;

  typedef struct packed {
    logic signed [RV_BITS-1:0] vx;
    logic signed [RV_BITS-1:0] vy;
    logic signed [D_BITS-1:0]  near_x;
    logic signed [D_BITS-1:0]  far_x;
    logic signed [D_BITS-1:0]  near_y;
    logic signed [D_BITS-1:0]  far_y;
    logic                      miss;
    side_t                     side;
  } stage_a_t;

  typedef struct packed {
    lane_kind_t          kind;
    logic [R_BITS-1:0]   rem;
    logic [Q_BITS-1:0]   quo;
  } lane_t;

  // lanes: x entry, x exit, y entry, y exit
  typedef struct packed {
    logic [DV_BITS-1:0]     dvx;
    logic [DV_BITS-1:0]     dvy;
    lane_t [N_LANES-1:0]    lane;
    logic                   miss;
    side_t                  side;
  } cell_data_t;

  function automatic side_t opposite(input side_t s);
    side_t r;
    case (s)
      SIDE_ABOVE: r = SIDE_BELOW;
      SIDE_BELOW: r = SIDE_ABOVE;
      SIDE_RIGHT: r = SIDE_LEFT;
      SIDE_LEFT:  r = SIDE_RIGHT;
      default:    r = SIDE_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/sac_prep.sv @@
// front stages: relative motion, broadphase, side pick, lane setup
// depends on sac_pkg
`timescale 1ns / 1ps
`default_nettype none

module sac_prep
  import sac_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] a_pos_x,
  input  wire logic signed [COORD_BITS-1:0] a_pos_y,
  input  wire logic [SIZE_BITS-1:0]         a_width,
  input  wire logic [SIZE_BITS-1:0]         a_height,
  input  wire logic signed [VEL_BITS-1:0]   a_vel_x,
  input  wire logic signed [VEL_BITS-1:0]   a_vel_y,
  input  wire logic signed [COORD_BITS-1:0] b_pos_x,
  input  wire logic signed [COORD_BITS-1:0] b_pos_y,
  input  wire logic [SIZE_BITS-1:0]         b_width,
  input  wire logic [SIZE_BITS-1:0]         b_height,
  input  wire logic signed [VEL_BITS-1:0]   b_vel_x,
  input  wire logic signed [VEL_BITS-1:0]   b_vel_y,
  output logic                              prep_valid,
  output cell_data_t                        prep_data
);

  logic signed [D_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh, vx, vy;
  logic signed [D_BITS-1:0] vx_max, vx_min, vy_max, vy_min;
  logic c0, c1, c2, c3;
  logic [2:0] cnt;
  side_t first, second, side_pick;
  stage_a_t sa_next, sa;
  logic sa_valid;

  always_comb begin
    ax = D_BITS'(a_pos_x);
    ay = D_BITS'(a_pos_y);
    aw = D_BITS'(a_width);
    ah = D_BITS'(a_height);
    bx = D_BITS'(b_pos_x);
    by = D_BITS'(b_pos_y);
    bw = D_BITS'(b_width);
    bh = D_BITS'(b_height);
    vx = D_BITS'(a_vel_x) - D_BITS'(b_vel_x);
    vy = D_BITS'(a_vel_y) - D_BITS'(b_vel_y);
    vx_max = (vx > 0) ? vx : '0;
    vx_min = (vx < 0) ? vx : '0;
    vy_max = (vy > 0) ? vy : '0;
    vy_min = (vy < 0) ? vy : '0;

    c0 = (ay + ah) <= by;
    c1 = ay >= (by + bh);
    c2 = ax >= (bx + bw);
    c3 = (ax + aw) <= bx;
    cnt = 3'(c0) + 3'(c1) + 3'(c2) + 3'(c3);
    first = c0 ? SIDE_ABOVE : c1 ? SIDE_BELOW : c2 ? SIDE_RIGHT : c3 ? SIDE_LEFT : SIDE_NONE;
    second = c3 ? SIDE_LEFT : c2 ? SIDE_RIGHT : c1 ? SIDE_BELOW : SIDE_NONE;
    if (cnt < 3'd2) begin
      side_pick = first;
    end else if (first == SIDE_ABOVE || first == SIDE_BELOW) begin
      side_pick = (vy != 0) ? second : SIDE_NONE;
    end else begin
      side_pick = (vx != 0) ? second : SIDE_NONE;
    end

    sa_next.vx     = RV_BITS'(vx);
    sa_next.vy     = RV_BITS'(vy);
    sa_next.near_x = bx - (ax + aw);
    sa_next.far_x  = (bx + bw) - ax;
    sa_next.near_y = by - (ay + ah);
    sa_next.far_y  = (by + bh) - ay;
    sa_next.miss   = ((ax + aw + vx_max) < (bx - SLACK)) || ((ax + vx_min) > (bx + bw)) ||
                     ((ay + ah + vy_max) < (by - SLACK)) || ((ay + vy_min) > (by + bh));
    sa_next.side   = side_pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (adv) begin
      sa_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa <= sa_next;
    end
  end

  // second stage: pick distances by motion sign and classify each lane
  logic signed [RV_BITS-1:0] v_ax [2];
  logic signed [D_BITS-1:0]  near_ax [2];
  logic signed [D_BITS-1:0]  far_ax [2];
  logic [DV_BITS-1:0]        dv_ax [2];
  cell_data_t                cd_next;

  always_comb begin
    v_ax[0]    = sa.vx;
    v_ax[1]    = sa.vy;
    near_ax[0] = sa.near_x;
    near_ax[1] = sa.near_y;
    far_ax[0]  = sa.far_x;
    far_ax[1]  = sa.far_y;
    dv_ax[0]   = DV_BITS'(sa.vx < 0 ? -sa.vx : sa.vx);
    dv_ax[1]   = DV_BITS'(sa.vy < 0 ? -sa.vy : sa.vy);
  end

  always_comb begin
    cd_next.dvx  = dv_ax[0];
    cd_next.dvy  = dv_ax[1];
    cd_next.miss = sa.miss;
    cd_next.side = sa.side;
    for (int i = 0; i < N_LANES; i++) begin
      logic signed [D_BITS-1:0] d;
      logic [D_BITS-1:0]        mag;
      logic                     sgn_diff;
      logic                     is_exit;
      int                       ax_i;
      lane_kind_t               kind;
      ax_i = i / 2;
      is_exit = (i % 2) == 1;
      if (is_exit) begin
        d = (v_ax[ax_i] > 0) ? far_ax[ax_i] : near_ax[ax_i];
      end else begin
        d = (v_ax[ax_i] > 0) ? near_ax[ax_i] : far_ax[ax_i];
      end
      mag = (d < 0) ? D_BITS'(-d) : D_BITS'(d);
      sgn_diff = (d < 0) ^ (v_ax[ax_i] < 0);
      if (v_ax[ax_i] == 0) begin
        kind = is_exit ? LK_BIG : LK_NEG;
      end else if (sgn_diff && mag != '0) begin
        kind = LK_NEG;
      end else if (mag >= D_BITS'({dv_ax[ax_i], 1'b0})) begin
        kind = LK_BIG;
      end else begin
        kind = LK_DIV;
      end
      cd_next.lane[i].kind = kind;
      cd_next.lane[i].rem  = mag[R_BITS-1:0];
      cd_next.lane[i].quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (adv) begin
      prep_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_data <= cd_next;
    end
  end

endmodule

`default_nettype wire

@@ src/sac_div_cell.sv @@
// one restoring division cell: one quotient bit for each of four lanes
// depends on sac_pkg
`timescale 1ns / 1ps
`default_nettype none

module sac_div_cell
  import sac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       d_valid,
  input  wire cell_data_t d_data,
  output logic            q_valid,
  output cell_data_t      q_data
);

  cell_data_t nxt;

  always_comb begin
    nxt = d_data;
    for (int i = 0; i < N_LANES; i++) begin
      logic [R_BITS-1:0] dv;
      logic              ge;
      logic [R_BITS-1:0] diff;
      dv   = R_BITS'((i < 2) ? d_data.dvx : d_data.dvy);
      ge   = d_data.lane[i].rem >= dv;
      diff = d_data.lane[i].rem - (ge ? dv : '0);
      nxt.lane[i].rem = {diff[R_BITS-2:0], 1'b0};
      nxt.lane[i].quo = {d_data.lane[i].quo[Q_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (adv) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_data <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sac_resolve.sv @@
// output stage: entry/exit compare, reject tests, result register
// depends on sac_pkg
`timescale 1ns / 1ps
`default_nettype none

module sac_resolve
  import sac_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           d_valid,
  input  wire cell_data_t     d_data,
  output logic                out_valid,
  output logic                hit,
  output logic [Q_BITS-1:0]   contact_time,
  output logic [2:0]          side_a,
  output logic [2:0]          side_b
);

  localparam logic signed [T_BITS-1:0] T_ONE = T_BITS'(TIME_ONE);
  localparam logic signed [T_BITS-1:0] T_BIG = T_BITS'(1) << Q_BITS;
  localparam logic signed [T_BITS-1:0] T_NEG = '1;

  logic signed [T_BITS-1:0] t [N_LANES];
  logic signed [T_BITS-1:0] entry, leave;
  logic                     reject;
  logic [Q_BITS-1:0]        time_next;
  side_t                    side_next;

  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      case (d_data.lane[i].kind)
        LK_DIV:  t[i] = T_BITS'(d_data.lane[i].quo);
        LK_NEG:  t[i] = T_NEG;
        LK_BIG:  t[i] = T_BIG;
        default: t[i] = T_BIG;
      endcase
    end
    entry  = (t[0] > t[2]) ? t[0] : t[2];
    leave  = (t[1] < t[3]) ? t[1] : t[3];
    reject = d_data.miss || (entry > leave) || (t[0] < 0 && t[2] < 0) ||
             (t[0] > T_ONE) || (t[2] > T_ONE);
    time_next = reject ? TIME_ONE : entry[Q_BITS-1:0];
    side_next = reject ? SIDE_NONE : d_data.side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= time_next < TIME_ONE;
      contact_time <= time_next;
      side_a       <= side_next;
      side_b       <= opposite(side_next);
    end
  end

endmodule

`default_nettype wire

@@ src/swept_aabb_collision_unit.sv @@
// top level of the swept box collision unit: prep stages, divider cell row, output stage
// depends on sac_pkg, sac_prep, sac_div_cell, sac_resolve
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | a_*, b_* position, size, velocity
// out     | out_valid / out_ready| hit, contact_time, side_a, side_b
//
// one item enters per cycle while the output is not stalled; the pipeline is two prep stages,
// 17 divider cells (one quotient bit each) and the output register
// the whole pipeline advances together when the output register is free or taken
// a stalled output holds every stage; reset clears all valid bits
`timescale 1ns / 1ps
`default_nettype none

module swept_aabb_collision_unit
  import sac_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] a_pos_x,
  input  wire logic signed [COORD_BITS-1:0] a_pos_y,
  input  wire logic [SIZE_BITS-1:0]         a_width,
  input  wire logic [SIZE_BITS-1:0]         a_height,
  input  wire logic signed [VEL_BITS-1:0]   a_vel_x,
  input  wire logic signed [VEL_BITS-1:0]   a_vel_y,
  input  wire logic signed [COORD_BITS-1:0] b_pos_x,
  input  wire logic signed [COORD_BITS-1:0] b_pos_y,
  input  wire logic [SIZE_BITS-1:0]         b_width,
  input  wire logic [SIZE_BITS-1:0]         b_height,
  input  wire logic signed [VEL_BITS-1:0]   b_vel_x,
  input  wire logic signed [VEL_BITS-1:0]   b_vel_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              hit,
  output logic [Q_BITS-1:0]                 contact_time,
  output logic [2:0]                        side_a,
  output logic [2:0]                        side_b
);

  logic       adv;
  logic       cv [N_CELLS+1];
  cell_data_t cd [N_CELLS+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  sac_prep u_prep (
    .clk, .rst, .adv, .in_valid,
    .a_pos_x, .a_pos_y, .a_width, .a_height, .a_vel_x, .a_vel_y,
    .b_pos_x, .b_pos_y, .b_width, .b_height, .b_vel_x, .b_vel_y,
    .prep_valid (cv[0]),
    .prep_data  (cd[0])
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    sac_div_cell u_cell (
      .clk, .rst, .adv,
      .d_valid (cv[k]),
      .d_data  (cd[k]),
      .q_valid (cv[k+1]),
      .q_data  (cd[k+1])
    );
  end

  sac_resolve u_resolve (
    .clk, .rst, .adv,
    .d_valid (cv[N_CELLS]),
    .d_data  (cd[N_CELLS]),
    .out_valid, .hit, .contact_time, .side_a, .side_b
  );

endmodule

`default_nettype wire

@@ src/sac_checker.sv @@
// port-level checks on the swept box collision unit, bound to the top level
// depends on sac_pkg and swept_aabb_collision_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "swept_aabb_collision_unit_defines.svh"

module sac_checker
  import sac_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              hit,
  input wire logic [Q_BITS-1:0] contact_time,
  input wire logic [2:0]        side_a,
  input wire logic [2:0]        side_b
);

  `SAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(contact_time) && $stable(side_a), "result changed while stalled")
  `SAC_ASSERT_NOW(a_hit_time, out_valid, hit == (contact_time != TIME_ONE), "hit disagrees with contact time")
  `SAC_ASSERT_NOW(a_time_range, out_valid && contact_time[Q_BITS-1], contact_time[Q_BITS-2:0] == '0, "contact time above one frame")
  `SAC_ASSERT_NOW(a_side_none, out_valid && side_a == SIDE_NONE, side_b == SIDE_NONE, "side of b set without side of a")
  `SAC_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind swept_aabb_collision_unit sac_checker u_sac_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for the swept box collision unit: directed and random box pairs
// predicts each result in-line and checks outputs in order; depends on sac_pkg
`timescale 1ns / 1ps

module testbench;
  import sac_pkg::*;

  localparam longint T1 = longint'(1) << TIME_FRAC_BITS;
  localparam longint PINF = longint'(1) << 62;

  typedef struct {
    longint ax, ay, aw, ah, avx, avy, bx, by, bw, bh, bvx, bvy;
  } pair_t;

  typedef struct {
    logic hit;
    logic [Q_BITS-1:0] t;
    logic [2:0] sa, sb;
  } contact_t;

  logic clk = 0, rst = 1, in_valid = 0, out_ready = 0;
  logic signed [COORD_BITS-1:0] a_pos_x = 0, a_pos_y = 0, b_pos_x = 0, b_pos_y = 0;
  logic [SIZE_BITS-1:0] a_width = 0, a_height = 0, b_width = 0, b_height = 0;
  logic signed [VEL_BITS-1:0] a_vel_x = 0, a_vel_y = 0, b_vel_x = 0, b_vel_y = 0;
  logic in_ready, out_valid, hit;
  logic [Q_BITS-1:0] contact_time;
  logic [2:0] side_a, side_b;

  contact_t expected_q[$];
  int errors = 0, n_sent = 0, n_hits = 0, n_checked = 0;

  swept_aabb_collision_unit u_top (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint fdiv(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q -= 1;
    return q;
  endfunction

  function automatic void axis(longint p, longint s, longint q, longint t, longint v,
                               output longint en, output longint ex);
    longint din, dout;
    if (v > 0) begin
      din = q - (p + s);
      dout = (q + t) - p;
    end else begin
      din = (q + t) - p;
      dout = q - (p + s);
    end
    if (v == 0) begin
      en = -PINF;
      ex = PINF;
    end else begin
      en = fdiv(din * T1, v);
      ex = fdiv(dout * T1, v);
    end
  endfunction

  function automatic side_t flip(side_t s);
    case (s)
      SIDE_ABOVE: return SIDE_BELOW;
      SIDE_BELOW: return SIDE_ABOVE;
      SIDE_RIGHT: return SIDE_LEFT;
      SIDE_LEFT: return SIDE_RIGHT;
      default: return SIDE_NONE;
    endcase
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint vx, vy, px, py, sx, sy, xe, xx, ye, yx, en, lv, tm;
    side_t side, first, second;
    bit miss;
    vx = p.avx - p.bvx;
    vy = p.avy - p.bvy;
    tm = T1;
    side = SIDE_NONE;
    px = (vx > 0) ? p.ax : p.ax + vx;
    py = (vy > 0) ? p.ay : p.ay + vy;
    sx = (vx > 0) ? p.aw + vx : p.aw - vx;
    sy = (vy > 0) ? p.ah + vy : p.ah - vy;
    miss = (px + sx < p.bx - 256) || (px > p.bx + p.bw) ||
           (py + sy < p.by - 256) || (py > p.by + p.bh);
    if (!miss) begin
      axis(p.ax, p.aw, p.bx, p.bw, vx, xe, xx);
      axis(p.ay, p.ah, p.by, p.bh, vy, ye, yx);
      en = (xe > ye) ? xe : ye;
      lv = (xx < yx) ? xx : yx;
      if (!(en > lv || (xe < 0 && ye < 0) || xe > T1 || ye > T1)) begin
        tm = en;
        first = SIDE_NONE;
        second = SIDE_NONE;
        if (p.ay + p.ah <= p.by) first = SIDE_ABOVE;
        if (p.ay >= p.by + p.bh) begin
          if (first == SIDE_NONE) first = SIDE_BELOW; else second = SIDE_BELOW;
        end
        if (p.ax >= p.bx + p.bw) begin
          if (first == SIDE_NONE) first = SIDE_RIGHT; else second = SIDE_RIGHT;
        end
        if (p.ax + p.aw <= p.bx) begin
          if (first == SIDE_NONE) first = SIDE_LEFT; else second = SIDE_LEFT;
        end
        if (second == SIDE_NONE) side = first;
        else if (first == SIDE_ABOVE || first == SIDE_BELOW)
          side = (vy != 0) ? second : SIDE_NONE;
        else side = (vx != 0) ? second : SIDE_NONE;
      end
    end
    c.hit = tm < T1;
    c.t = tm[Q_BITS-1:0];
    c.sa = side;
    c.sb = flip(side);
    return c;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pair(pair_t p);
    idle_gap();
    a_pos_x <= COORD_BITS'(p.ax);
    a_pos_y <= COORD_BITS'(p.ay);
    a_width <= SIZE_BITS'(p.aw);
    a_height <= SIZE_BITS'(p.ah);
    a_vel_x <= VEL_BITS'(p.avx);
    a_vel_y <= VEL_BITS'(p.avy);
    b_pos_x <= COORD_BITS'(p.bx);
    b_pos_y <= COORD_BITS'(p.by);
    b_width <= SIZE_BITS'(p.bw);
    b_height <= SIZE_BITS'(p.bh);
    b_vel_x <= VEL_BITS'(p.bvx);
    b_vel_y <= VEL_BITS'(p.bvy);
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_contact(p));
    n_sent++;
  endtask

  // sink side: random stall, compare in order
  initial begin
    contact_t e;
    int gap;
    gap = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          n_checked++;
          if (e.hit) n_hits++;
          if (hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, hit); errors++;
          end
          if (contact_time !== e.t) begin
            $error("contact_time exp %0d got %0d", e.t, contact_time); errors++;
          end
          if (side_a !== e.sa) begin
            $error("side_a exp %0d got %0d", e.sa, side_a); errors++;
          end
          if (side_b !== e.sb) begin
            $error("side_b exp %0d got %0d", e.sb, side_b); errors++;
          end
        end
      end
      if (gap > 0) begin
        gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 5) == 0)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      end
    end
  end

  function automatic longint rnd_s(int bits);
    longint v;
    v = {$urandom(), $urandom()};
    v = v & ((longint'(1) << bits) - 1);
    if (v[bits-1]) v -= longint'(1) << bits;
    return v;
  endfunction

  function automatic longint rnd_u(int bits);
    longint v;
    v = {$urandom(), $urandom()};
    return v & ((longint'(1) << bits) - 1);
  endfunction

  localparam longint CMAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint SMAX = (longint'(1) << SIZE_BITS) - 1;
  localparam longint VMAX = (longint'(1) << (VEL_BITS - 1)) - 1;

  task automatic test_directed();
    pair_t p;
    // approach from each side
    p = '{0, 0, 2560, 2560, 512, 0, 3000, 0, 2560, 2560, 0, 0}; send_pair(p);
    p = '{6000, 0, 2560, 2560, -512, 0, 3000, 0, 2560, 2560, 0, 0}; send_pair(p);
    p = '{0, 0, 2560, 2560, 0, 512, 0, 3000, 2560, 2560, 0, 0}; send_pair(p);
    p = '{0, 6000, 2560, 2560, 0, -512, 0, 3000, 2560, 2560, 0, 0}; send_pair(p);
    // contact exactly at one frame
    p = '{0, 0, 256, 256, 256, 0, 512, 0, 256, 256, 0, 0}; send_pair(p);
    // diagonal corner, two separating sides
    p = '{0, 0, 256, 256, 512, 512, 512, 512, 256, 256, 0, 0}; send_pair(p);
    p = '{0, 0, 256, 256, 512, 0, 300, 300, 256, 256, 0, 0}; send_pair(p);
    // zero relative velocity, overlap and apart
    p = '{0, 0, 1000, 1000, 300, 300, 500, 500, 1000, 1000, 300, 300}; send_pair(p);
    p = '{0, 0, 100, 100, 0, 0, 50000, 0, 100, 100, 0, 0}; send_pair(p);
    // degenerate zero sizes
    p = '{0, 0, 0, 0, 256, 256, 100, 100, 0, 0, 0, 0}; send_pair(p);
    // within slack
    p = '{0, 0, 256, 256, 0, 0, 400, 0, 256, 256, 0, 0}; send_pair(p);
    // extremes
    p = '{CMAX, CMAX, SMAX, SMAX, VMAX, VMAX, -CMAX-1, -CMAX-1, SMAX, SMAX,
          -VMAX-1, -VMAX-1}; send_pair(p);
    p = '{-CMAX-1, -CMAX-1, 0, 0, -VMAX-1, -VMAX-1, CMAX, CMAX, 0, 0, VMAX, VMAX};
    send_pair(p);
    p = '{-CMAX-1, 0, SMAX, SMAX, VMAX, -VMAX-1, -CMAX-1, 0, SMAX, SMAX, -VMAX-1, VMAX};
    send_pair(p);
    // already overlapping and moving
    p = '{100, 100, 1000, 1000, 256, -128, 200, 200, 1000, 1000, 0, 0}; send_pair(p);
  endtask

  task automatic test_random();
    pair_t p;
    int k;
    for (int i = 0; i < 1750; i++) begin
      k = $urandom_range(0, 9);
      if (k < 2) begin
        p = '{rnd_s(COORD_BITS), rnd_s(COORD_BITS), rnd_u(SIZE_BITS), rnd_u(SIZE_BITS),
              rnd_s(VEL_BITS), rnd_s(VEL_BITS), rnd_s(COORD_BITS), rnd_s(COORD_BITS),
              rnd_u(SIZE_BITS), rnd_u(SIZE_BITS), rnd_s(VEL_BITS), rnd_s(VEL_BITS)};
      end else begin
        // nearby boxes so the sweep often reaches
        p.bx = rnd_s(COORD_BITS - 2);
        p.by = rnd_s(COORD_BITS - 2);
        p.ax = p.bx + rnd_s(k < 6 ? 14 : 18);
        p.ay = p.by + rnd_s(k < 6 ? 14 : 18);
        p.aw = rnd_u(k < 6 ? 12 : 16);
        p.ah = rnd_u(k < 6 ? 12 : 16);
        p.bw = rnd_u(k < 6 ? 12 : 16);
        p.bh = rnd_u(k < 6 ? 12 : 16);
        p.avx = ($urandom_range(0, 7) == 0) ? 0 : rnd_s(VEL_BITS);
        p.avy = ($urandom_range(0, 7) == 0) ? 0 : rnd_s(VEL_BITS);
        p.bvx = ($urandom_range(0, 3) == 0) ? p.avx : rnd_s(k < 6 ? 10 : VEL_BITS);
        p.bvy = ($urandom_range(0, 3) == 0) ? p.avy : rnd_s(k < 6 ? 10 : VEL_BITS);
      end
      send_pair(p);
    end
  endtask

  initial begin
    int w;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 0;
    w = 0;
    while (expected_q.size() != 0 && w < 100000) begin
      @(posedge clk);
      w++;
    end
    repeat (30) @(posedge clk);
    $display("sent %0d box pairs, checked %0d results, %0d with contact",
             n_sent, n_checked, n_hits);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_q.size() != 0) $error("%0d results never came", expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/sac_pkg.sv
src/sac_prep.sv
src/sac_div_cell.sv
src/sac_resolve.sv
src/swept_aabb_collision_unit.sv
src/sac_checker.sv
tb/testbench.sv
